[design/gsaps_pkg.sv]
// ----------------------------------------------------------------------------
// gsaps_pkg
// Shared types and constants for the gas sensor array poll scheduler.
// ----------------------------------------------------------------------------
package gsaps_pkg;

  // Array geometry
  localparam int SENSOR_COUNT = 8;
  localparam int SENSOR_W     = $clog2(SENSOR_COUNT);
  localparam int MAX_FIELDS   = 3;
  localparam int FIELD_W      = 2;

  // Fixed widths of the register set
  localparam int TIME_W       = 32;
  localparam int HEATER_W     = 32;
  localparam int MASK_W       = 8;
  localparam int WAIT_W       = 16;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_LENGTHS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIGURED_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_WAIT_MS     = 2'd2;

  // Reset values
  localparam logic [HEATER_W-1:0] HEATER_RESET   = 32'hAAAA_AAAA;
  localparam logic [MASK_W-1:0]   MASK_RESET     = 8'h00;
  localparam logic [WAIT_W-1:0]   GAS_WAIT_RESET = 16'd140;

  // Select window past the current time
  localparam logic [TIME_W-1:0] SELECT_LOOKAHEAD = 32'd20;

  typedef enum logic {
    OP_SELECT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_SELECTED = 3'd0,
    ST_NONE     = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_WAKE     = 3'd3,
    ST_NO_MATCH = 3'd4,
    ST_ACCEPTED = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_FIELD,
    S_WRITE,
    S_FINISH
  } state_e;

  // Request payload
  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now_ms;
    logic [3:0]        sensor_index;
    logic [1:0]        field_count;
    logic [2:0]        field_valid;
    logic [3:0]        gas_step_0;
    logic [3:0]        gas_step_1;
    logic [3:0]        gas_step_2;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] chosen_sensor;
    logic [1:0] field_used;
    logic [3:0] step_used;
  } out_item_t;

  // Sensor bank write request
  typedef struct packed {
    logic                en;
    logic [SENSOR_W-1:0] addr;
    logic [TIME_W-1:0]   wake;
    logic                step_en;
    logic [3:0]          step;
  } bank_wr_t;

  // Sensor bank read data
  typedef struct packed {
    logic              running;
    logic [TIME_W-1:0] wake;
    logic [3:0]        step;
  } bank_rd_t;

endpackage

[design/gsaps_alu.sv]
// ----------------------------------------------------------------------------
// gsaps_alu
// Shared 32-bit unit: unsigned less-than and saturating add of one operand pair.
// ----------------------------------------------------------------------------
module gsaps_alu
  import gsaps_pkg::*;
(
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  output logic              lt_o,
  output logic [TIME_W-1:0] sum_o
);

  logic [TIME_W:0] raw_sum;

  // Carry out means overflow: clamp to all ones
  assign raw_sum = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o   = raw_sum[TIME_W] ? {TIME_W{1'b1}} : raw_sum[TIME_W-1:0];
  assign lt_o    = a_i < b_i;

endmodule

[design/gsaps_sensor_bank.sv]
// ----------------------------------------------------------------------------
// gsaps_sensor_bank
// Per-sensor mode, wake time and expected heater step. One read port, one
// write port, and a clear that returns every sensor to sleeping, due at once.
// ----------------------------------------------------------------------------
module gsaps_sensor_bank
  import gsaps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  bank_wr_t            wr_i,
  input  logic [SENSOR_W-1:0] rd_addr_i,
  output bank_rd_t            rd_o
);

  logic              running_q [SENSOR_COUNT];
  logic [TIME_W-1:0] wake_q    [SENSOR_COUNT];
  logic [3:0]        step_q    [SENSOR_COUNT];

  // Storage update; a clear wins over a write, and a write leaves the sensor running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        running_q[i] <= 1'b0;
        wake_q[i]    <= '0;
        step_q[i]    <= '0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        running_q[i] <= 1'b0;
        wake_q[i]    <= '0;
        step_q[i]    <= '0;
      end
    end else if (wr_i.en) begin
      running_q[wr_i.addr] <= 1'b1;
      wake_q[wr_i.addr]    <= wr_i.wake;
      if (wr_i.step_en) begin
        step_q[wr_i.addr] <= wr_i.step;
      end
    end
  end

  assign rd_o.running = running_q[rd_addr_i];
  assign rd_o.wake    = wake_q[rd_addr_i];
  assign rd_o.step    = step_q[rd_addr_i];

endmodule

[design/gas_sensor_array_poll_scheduler.sv]
// ----------------------------------------------------------------------------
// gas_sensor_array_poll_scheduler
// Picks the next sensor to poll and books reads of a sensor array.
// ----------------------------------------------------------------------------
// One request at a time: a sequencer walks the sensor bank one entry per cycle
// through a single shared compare/saturating-add unit. A select request scans
// the bank in eight scan steps, and scans the sleeping sensors too when no
// running sensor is due. A refused read request goes from its checks straight
// to the last step, and one that wakes the sensor adds a wake time update; a
// read of a running sensor takes one due check, one step per fetched field
// examined (plus one to close the search when no field matches), and one wake
// time update. The result sits in an output register; the block waits in its
// last step only if the previous result has not been taken. A write to any
// of the three configuration registers returns every sensor to sleeping, due at once.
module gas_sensor_array_poll_scheduler
  import gsaps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [HEATER_W-1:0] heater_q;
  logic [MASK_W-1:0]   mask_q;
  logic [WAIT_W-1:0]   wait_q;
  logic                cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_index_i == CFG_HEATER_LENGTHS ||
                                cfg_index_i == CFG_CONFIGURED_MASK ||
                                cfg_index_i == CFG_GAS_WAIT_MS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q <= HEATER_RESET;
      mask_q   <= MASK_RESET;
      wait_q   <= GAS_WAIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEATER_LENGTHS:  heater_q <= cfg_wdata_i[HEATER_W-1:0];
        CFG_CONFIGURED_MASK: mask_q   <= cfg_wdata_i[MASK_W-1:0];
        CFG_GAS_WAIT_MS:     wait_q   <= cfg_wdata_i[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_e              state_q, state_d;
  in_item_t            item_q, item_d;
  logic [TIME_W-1:0]   bound_q, bound_d;
  logic [SENSOR_W-1:0] idx_q, idx_d;
  logic                mode_q, mode_d;
  logic                found_q, found_d;
  logic [SENSOR_W-1:0] sel_q, sel_d;
  logic [FIELD_W-1:0]  fld_q, fld_d;
  status_e             status_q, status_d;
  logic [3:0]          hstep_q, hstep_d;
  logic [FIELD_W-1:0]  used_q, used_d;
  logic                step_we_q, step_we_d;
  logic [3:0]          new_step_q, new_step_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  // Shared unit and bank hookup
  logic [TIME_W-1:0]   alu_a, alu_b, alu_sum;
  logic                alu_lt;
  logic [SENSOR_W-1:0] rd_addr;
  bank_rd_t            rd;
  bank_wr_t            wr;

  gsaps_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lt_o  (alu_lt),
    .sum_o (alu_sum)
  );

  gsaps_sensor_bank u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_hit),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  // Field match helpers for the current field
  logic [SENSOR_W-1:0] read_addr;
  logic [3:0]          heater_len;
  logic [FIELD_W-1:0]  field_lim;
  logic [3:0]          cur_step;
  logic [5:0]          delta_raw, delta;
  logic [4:0]          step_inc;
  logic                field_match;

  assign read_addr  = item_q.sensor_index[SENSOR_W-1:0];
  assign heater_len = heater_q[{read_addr, 2'b00} +: 4];
  assign field_lim  = (item_q.field_count > FIELD_W'(MAX_FIELDS)) ?
                      FIELD_W'(MAX_FIELDS) : item_q.field_count;

  always_comb begin
    case (fld_q)
      2'd0:    cur_step = item_q.gas_step_0;
      2'd1:    cur_step = item_q.gas_step_1;
      default: cur_step = item_q.gas_step_2;
    endcase
  end

  // Distance ahead of the expected step, wrapped by the heater length
  assign delta_raw   = {2'b00, cur_step} - {2'b00, rd.step};
  assign delta       = delta_raw[5] ? delta_raw + {2'b00, heater_len} : delta_raw;
  assign field_match = item_q.field_valid[fld_q] && !delta[5] &&
                       (delta < {2'b00, heater_len});
  assign step_inc    = {1'b0, cur_step} + 5'd1;

  // Operand and address selection
  always_comb begin
    case (state_q)
      S_IDLE: begin
        alu_a = in_data_i.now_ms;
        alu_b = SELECT_LOOKAHEAD;
      end
      S_SCAN: begin
        alu_a = rd.wake;
        alu_b = bound_q;
      end
      S_CHECK: begin
        alu_a = item_q.now_ms;
        alu_b = rd.wake;
      end
      default: begin
        alu_a = item_q.now_ms;
        alu_b = {{(TIME_W-WAIT_W){1'b0}}, wait_q};
      end
    endcase
  end

  assign rd_addr = (state_q == S_SCAN) ? idx_q : read_addr;

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    bound_d     = bound_q;
    idx_d       = idx_q;
    mode_d      = mode_q;
    found_d     = found_q;
    sel_d       = sel_q;
    fld_d       = fld_q;
    status_d    = status_q;
    hstep_d     = hstep_q;
    used_d      = used_q;
    step_we_d   = step_we_q;
    new_step_d  = new_step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr          = '0;
    wr.addr     = read_addr;
    wr.wake     = alu_sum;
    wr.step     = new_step_q;
    wr.step_en  = step_we_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          bound_d   = alu_sum;
          idx_d     = '0;
          mode_d    = 1'b1;
          found_d   = 1'b0;
          sel_d     = '0;
          fld_d     = '0;
          hstep_d   = '0;
          used_d    = '0;
          step_we_d = 1'b0;
          state_d   = (in_data_i.op == OP_READ) ? S_CHECK : S_SCAN;
        end
      end

      // Earliest sensor of the current mode below the bound
      S_SCAN: begin
        if (rd.running == mode_q && alu_lt) begin
          bound_d = rd.wake;
          found_d = 1'b1;
          sel_d   = idx_q;
        end
        if (idx_q == SENSOR_W'(SENSOR_COUNT - 1)) begin
          idx_d = '0;
          if (mode_q && !(found_d)) begin
            mode_d = 1'b0;
          end else begin
            status_d = found_d ? ST_SELECTED : ST_NONE;
            state_d  = S_FINISH;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Range, configured and due checks
      S_CHECK: begin
        if (item_q.sensor_index >= 4'(SENSOR_COUNT) || !mask_q[read_addr] || alu_lt) begin
          status_d = ST_REFUSED;
          state_d  = S_FINISH;
        end else if (!rd.running) begin
          status_d   = ST_WAKE;
          step_we_d  = 1'b1;
          new_step_d = '0;
          state_d    = S_WRITE;
        end else begin
          state_d = S_FIELD;
        end
      end

      // One fetched field per cycle
      S_FIELD: begin
        if (fld_q >= field_lim) begin
          status_d = ST_NO_MATCH;
          state_d  = S_WRITE;
        end else if (field_match) begin
          status_d   = ST_ACCEPTED;
          used_d     = fld_q;
          hstep_d    = cur_step;
          step_we_d  = 1'b1;
          new_step_d = (step_inc >= {1'b0, heater_len}) ? 4'd0 : step_inc[3:0];
          state_d    = S_WRITE;
        end else begin
          fld_d = fld_q + 1'b1;
        end
      end

      // Wake time update, and step update when asked
      S_WRITE: begin
        wr.en   = 1'b1;
        state_d = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.chosen_sensor = (item_q.op == OP_READ) ? item_q.sensor_index
                                                        : 4'(sel_q);
          out_d.field_used    = used_q;
          out_d.step_used     = hstep_q;
          state_d             = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    bound_q    <= bound_d;
    idx_q      <= idx_d;
    mode_q     <= mode_d;
    found_q    <= found_d;
    sel_q      <= sel_d;
    fld_q      <= fld_d;
    status_q   <= status_d;
    hstep_q    <= hstep_d;
    used_q     <= used_d;
    step_we_q  <= step_we_d;
    new_step_q <= new_step_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new request always starts a multi-cycle sequence
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted but sequencer stayed idle");

  // A fresh result only comes out of the last step
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result raised outside the finish step");

  // Field and step are reported only for an accepted reading
  a_fields_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_ACCEPTED |->
      out_data_o.field_used == '0 && out_data_o.step_used == '0)
    else $error("field data reported without an accepted reading");

endmodule
